// File: rtl/apbos_pkg.sv
// Shared constants, types and helpers for the all-pairs box overlap scan.
package apbos_pkg;

  localparam int MAX_ENTITIES = 32;
  localparam int ID_W         = 5;
  localparam int ID_REACH     = 32;
  localparam int CNT_W        = 6;
  localparam int EDGE_W       = 18;
  localparam int TBL_AW       = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int SCAN_MAX     = (MAX_ENTITIES < ID_REACH) ? MAX_ENTITIES : ID_REACH;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    edge_t left;
    edge_t right;
    edge_t top;
    edge_t bottom;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Scan counter value to table address; callers keep the value below MAX_ENTITIES.
  function automatic logic [TBL_AW-1:0] to_addr(input logic [CNT_W-1:0] v);
    logic [TBL_AW+CNT_W-1:0] ext;
    ext = {{TBL_AW{1'b0}}, v};
    return ext[TBL_AW-1:0];
  endfunction

  // Strict overlap: touching edges do not count.
  function automatic logic boxes_overlap(input entry_t a, input entry_t b);
    return ($signed(a.right) > $signed(b.left)) && ($signed(a.left) < $signed(b.right)) &&
           ($signed(a.bottom) > $signed(b.top)) && ($signed(a.top) < $signed(b.bottom));
  endfunction

endpackage

// File: rtl/apbos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apbos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/all_pairs_box_overlap_scan.sv
// Top level: entity box table with an iterative all-pairs overlap scan.
//
// Input channel (in_valid/in_ready) takes one item: a load writes one table
// entry (edges from position, offset and size, plus the live flag) and is
// taken with no result. A query names entity A and scans every entity B
// with A < B < min(entity_count, 32) through one shared overlap comparator,
// one table entry per cycle unless a stall holds the scan, read from a
// single-port-read RAM. in_ready is low while a query runs.
// Result channel (out_valid/out_ready) gives one item per overlapping pair,
// the final one flagged last_of_run, or a single not-found item. A found pair
// is held back one step so the last flag is known when it goes out.
// When the receiver stalls, the output register holds and the scan pauses on
// the next hit while a pair is held. A query's last result may still wait in
// the output register while the next item is accepted.
// cfg_wr_en writes entity_count in the same cycle; use only while idle (unchecked).
// Reset (rst_n low, synchronous) clears all live flags, entity_count and the
// control state; box edges are undefined until loaded.
module all_pairs_box_overlap_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [apbos_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [apbos_pkg::ID_W-1:0]    in_entity_index,
  input  logic signed [15:0]            in_pos_x,
  input  logic signed [15:0]            in_pos_y,
  input  logic signed [15:0]            in_box_off_x,
  input  logic signed [15:0]            in_box_off_y,
  input  logic [15:0]                   in_box_width,
  input  logic [15:0]                   in_box_height,
  input  logic                          in_entity_live,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apbos_pkg::ID_W-1:0]    out_first_entity,
  output logic [apbos_pkg::ID_W-1:0]    out_second_entity,
  output logic                          out_pair_found,
  output logic                          out_last_of_run
);

  localparam int EW = $bits(apbos_pkg::entry_t);

  apbos_pkg::state_t                  state_r, state_nxt;
  logic [apbos_pkg::CNT_W-1:0]        entity_count_r;
  logic [apbos_pkg::MAX_ENTITIES-1:0] live_r, live_nxt;
  logic [apbos_pkg::ID_W-1:0]         a_idx_r, a_idx_nxt;
  logic [apbos_pkg::CNT_W-1:0]        limit_r, limit_nxt;
  logic [apbos_pkg::CNT_W-1:0]        b_r, b_nxt;
  logic                               c_vld_r, c_vld_nxt;
  logic [apbos_pkg::ID_W-1:0]         c_b_r, c_b_nxt;
  logic                               pend_vld_r, pend_vld_nxt;
  logic [apbos_pkg::ID_W-1:0]         pend_b_r, pend_b_nxt;
  apbos_pkg::entry_t                  a_box_r, a_box_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [apbos_pkg::ID_W-1:0]         out_first_r, out_first_nxt;
  logic [apbos_pkg::ID_W-1:0]         out_second_r, out_second_nxt;
  logic                               out_found_r, out_found_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               ram_we;
  logic [apbos_pkg::TBL_AW-1:0]       ram_waddr;
  logic                               ram_re;
  logic [apbos_pkg::TBL_AW-1:0]       ram_raddr;
  logic [EW-1:0]                      ram_rdata;
  apbos_pkg::entry_t                  ld_box;
  apbos_pkg::entry_t                  rd_box;

  logic [apbos_pkg::CNT_W-1:0]        idx_ext;
  logic [apbos_pkg::CNT_W-1:0]        q_limit;
  logic                               idx_in_table;
  logic                               a_ok;
  logic                               out_free;
  logic                               hit;
  logic                               stall;

  // Load-side edge arithmetic
  always_comb begin
    ld_box.left   = apbos_pkg::EDGE_W'(in_pos_x) + apbos_pkg::EDGE_W'(in_box_off_x);
    ld_box.top    = apbos_pkg::EDGE_W'(in_pos_y) + apbos_pkg::EDGE_W'(in_box_off_y);
    ld_box.right  = ld_box.left + $signed({2'b00, in_box_width});
    ld_box.bottom = ld_box.top + $signed({2'b00, in_box_height});
  end

  assign rd_box       = apbos_pkg::entry_t'(ram_rdata);
  assign idx_ext      = {1'b0, in_entity_index};
  assign idx_in_table = (32'(in_entity_index) < apbos_pkg::MAX_ENTITIES);
  assign q_limit      = (entity_count_r < apbos_pkg::CNT_W'(apbos_pkg::SCAN_MAX)) ?
                        entity_count_r : apbos_pkg::CNT_W'(apbos_pkg::SCAN_MAX);
  assign a_ok         = (idx_ext < q_limit) && live_r[apbos_pkg::to_addr(idx_ext)];
  assign ram_waddr    = apbos_pkg::to_addr(idx_ext);

  assign out_free = !out_valid_r || out_ready;
  assign hit      = c_vld_r && live_r[apbos_pkg::to_addr({1'b0, c_b_r})] &&
                    apbos_pkg::boxes_overlap(a_box_r, rd_box);
  // a hit must push the held pair out first
  assign stall    = hit && pend_vld_r && !out_free;

  apbos_ram #(
    .WIDTH (EW),
    .DEPTH (apbos_pkg::MAX_ENTITIES)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ld_box),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    a_idx_nxt      = a_idx_r;
    limit_nxt      = limit_r;
    b_nxt          = b_r;
    c_vld_nxt      = c_vld_r;
    c_b_nxt        = c_b_r;
    pend_vld_nxt   = pend_vld_r;
    pend_b_nxt     = pend_b_r;
    a_box_nxt      = a_box_r;
    out_valid_nxt  = out_valid_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = apbos_pkg::to_addr(b_r);
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      apbos_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == apbos_pkg::REQ_LOAD) begin
            if (idx_in_table) begin
              ram_we = 1'b1;
              live_nxt[apbos_pkg::to_addr(idx_ext)] = in_entity_live;
            end
          end else begin
            a_idx_nxt    = in_entity_index;
            limit_nxt    = q_limit;
            b_nxt        = idx_ext + apbos_pkg::CNT_W'(1);
            c_vld_nxt    = 1'b0;
            pend_vld_nxt = 1'b0;
            if (a_ok) begin
              ram_re    = 1'b1;
              ram_raddr = apbos_pkg::to_addr(idx_ext);
              state_nxt = apbos_pkg::ST_LOAD_A;
            end else begin
              state_nxt = apbos_pkg::ST_FINISH;
            end
          end
        end
      end

      apbos_pkg::ST_LOAD_A: begin
        a_box_nxt = rd_box;
        if (b_r < limit_r) begin
          ram_re    = 1'b1;
          c_vld_nxt = 1'b1;
          c_b_nxt   = b_r[apbos_pkg::ID_W-1:0];
          b_nxt     = b_r + apbos_pkg::CNT_W'(1);
        end
        state_nxt = apbos_pkg::ST_SCAN;
      end

      apbos_pkg::ST_SCAN: begin
        if (!c_vld_r && (b_r >= limit_r)) begin
          state_nxt = apbos_pkg::ST_FINISH;
        end else if (!stall) begin
          if (hit) begin
            if (pend_vld_r) begin
              out_valid_nxt  = 1'b1;
              out_first_nxt  = a_idx_r;
              out_second_nxt = pend_b_r;
              out_found_nxt  = 1'b1;
              out_last_nxt   = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_b_nxt   = c_b_r;
          end
          if (b_r < limit_r) begin
            ram_re    = 1'b1;
            c_vld_nxt = 1'b1;
            c_b_nxt   = b_r[apbos_pkg::ID_W-1:0];
            b_nxt     = b_r + apbos_pkg::CNT_W'(1);
          end else begin
            c_vld_nxt = 1'b0;
          end
        end
      end

      apbos_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = a_idx_r;
          out_second_nxt = pend_vld_r ? pend_b_r : '0;
          out_found_nxt  = pend_vld_r;
          out_last_nxt   = 1'b1;
          pend_vld_nxt   = 1'b0;
          state_nxt      = apbos_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = apbos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= apbos_pkg::ST_IDLE;
      entity_count_r <= '0;
      live_r         <= '0;
      c_vld_r        <= 1'b0;
      pend_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      c_vld_r     <= c_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        entity_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r      <= a_idx_nxt;
    limit_r      <= limit_nxt;
    b_r          <= b_nxt;
    c_b_r        <= c_b_nxt;
    pend_b_r     <= pend_b_nxt;
    a_box_r      <= a_box_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_found_r  <= out_found_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_first_entity  = out_first_r;
  assign out_second_entity = out_second_r;
  assign out_pair_found    = out_found_r;
  assign out_last_of_run   = out_last_r;

  // no scan leftovers once back in idle
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apbos_pkg::ST_IDLE) |-> (!pend_vld_r && !c_vld_r))
    else $error("scan state left over in idle");

  // the scan pointer never runs past the limit
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apbos_pkg::ST_SCAN) |-> (b_r <= limit_r))
    else $error("scan pointer beyond limit");

  // only entities above A are compared
  a_b_above_a: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r |-> (c_b_r > a_idx_r))
    else $error("compared entity not above A");

  // a not-found item is always last and names no partner
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_last_r && (out_second_r == '0)))
    else $error("malformed not-found item");

  // a finished query with a held pair must emit it as found
  a_finish_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == apbos_pkg::ST_FINISH) && out_free && pend_vld_r) |=>
      (out_valid_r && out_found_r && out_last_r))
    else $error("held pair lost at end of scan");

endmodule
